/* hdl/cfhd_pkg.sv */
// ----------------------------------------------------------------------------
// Chirp frame header decoder package
// Shared types and constants for the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package cfhd_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_IMPLICIT_MODE        = 3'd0;
   localparam logic [2:0] CSR_FIXED_CODING_RATE    = 3'd1;
   localparam logic [2:0] CSR_FIXED_PAYLOAD_LENGTH = 3'd2;
   localparam logic [2:0] CSR_FIXED_CRC_PRESENT    = 3'd3;
   localparam logic [2:0] CSR_FIXED_LOW_RATE_OPT   = 3'd4;

   localparam logic [2:0] RESET_CODING_RATE = 3'd1;

   // Work handed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_DATA     = 2'd0,
      OP_IMPLICIT = 2'd1,
      OP_HEADER   = 2'd2
   } cfhd_op_type;

   typedef struct packed {
      cfhd_op_type      op;
      logic [3:0]       sym;
      logic [3:0][3:0]  nibbles;
   } cfhd_entry_type;

   typedef struct packed {
      logic       implicit_mode;
      logic [2:0] fixed_coding_rate;
      logic [7:0] fixed_payload_length;
      logic       fixed_crc_present;
      logic       fixed_low_rate_opt;
   } cfhd_cfg_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] data;
      logic [7:0] payload_length;
      logic [2:0] coding_rate;
      logic       crc_present;
      logic       low_rate_opt;
      logic       header_error;
      logic       last;
   } cfhd_rsp_type;

endpackage

/* hdl/cfhd_if.sv */
// ----------------------------------------------------------------------------
// Chirp frame header decoder channels
// Valid/ready channels for incoming symbols and outgoing results.
// ----------------------------------------------------------------------------
interface cfhd_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] symbol;
   logic       frame_mark;
   logic       mark_is_header;

   modport source (output valid, symbol, frame_mark, mark_is_header, input ready);
   modport sink   (input valid, symbol, frame_mark, mark_is_header, output ready);
endinterface

interface cfhd_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [3:0] data;
   logic [7:0] payload_length;
   logic [2:0] coding_rate;
   logic       crc_present;
   logic       low_rate_opt;
   logic       header_error;
   logic       last;

   modport source (output valid, kind, data, payload_length, coding_rate, crc_present,
                   low_rate_opt, header_error, last, input ready);
   modport sink   (input valid, kind, data, payload_length, coding_rate, crc_present,
                   low_rate_opt, header_error, last, output ready);
endinterface

/* hdl/chirp_frame_header_decoder.sv */
// ----------------------------------------------------------------------------
// Chirp frame header decoder
// Gathers and checks explicit frame headers and forwards payload symbols.
// ----------------------------------------------------------------------------
// The block takes one symbol per cycle while the work queue is not full.
// Header nibbles are absorbed without a result; the fifth nibble yields one
// frame record, a payload symbol one data result, and in implicit mode a
// header-marked symbol yields a frame record followed by the symbol.
// An accepted symbol enters the work queue and from there moves into the
// output register. The output register sets the rate at one result per
// cycle while the receiver takes results.
module chirp_frame_header_decoder import cfhd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   cfhd_req_if.sink    req_chan,
   cfhd_rsp_if.source  rsp_chan,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   cfhd_cfg_type   cfg_ff, cfg_in;
   logic           push, pop, q_full, head_valid;
   cfhd_entry_type push_entry, head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMPLICIT_MODE:        cfg_in.implicit_mode        = csr_write_data[0];
            CSR_FIXED_CODING_RATE:    cfg_in.fixed_coding_rate    = csr_write_data[2:0];
            CSR_FIXED_PAYLOAD_LENGTH: cfg_in.fixed_payload_length = csr_write_data;
            CSR_FIXED_CRC_PRESENT:    cfg_in.fixed_crc_present    = csr_write_data[0];
            CSR_FIXED_LOW_RATE_OPT:   cfg_in.fixed_low_rate_opt   = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.implicit_mode        <= 1'b0;
         cfg_ff.fixed_coding_rate    <= RESET_CODING_RATE;
         cfg_ff.fixed_payload_length <= 8'd0;
         cfg_ff.fixed_crc_present    <= 1'b0;
         cfg_ff.fixed_low_rate_opt   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfhd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .implicit_mode (cfg_ff.implicit_mode),
      .req           (req_chan),
      .q_full        (q_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   cfhd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   cfhd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

/* hdl/cfhd_queue.sv */
// ----------------------------------------------------------------------------
// Chirp frame header decoder work queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cfhd_queue import cfhd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cfhd_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output cfhd_entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cfhd_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count out of range");
`endif

endmodule

/* hdl/cfhd_front.sv */
// ----------------------------------------------------------------------------
// Chirp frame header decoder front end
// Accepts symbols, gathers header nibbles and queues work for the back end.
// ----------------------------------------------------------------------------
module cfhd_front import cfhd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           implicit_mode,
   cfhd_req_if.sink       req,
   input  logic           q_full,
   output logic           push,
   output cfhd_entry_type push_entry
);

   localparam logic [2:0] HDR_STORED = 3'd4;

   logic            in_header_ff, in_header_in;
   logic [2:0]      header_count_ff, header_count_in;
   logic [3:0][3:0] header_store_ff;
   logic            store_we;
   logic [1:0]      store_idx;
   logic            accept;
   logic            hdr_now;
   logic [2:0]      count_now;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_header_in       = in_header_ff;
      header_count_in    = header_count_ff;
      store_we           = 1'b0;
      store_idx          = header_count_ff[1:0];
      push               = 1'b0;
      push_entry.op      = OP_DATA;
      push_entry.sym     = req.symbol;
      push_entry.nibbles = header_store_ff;
      hdr_now            = req.frame_mark ? req.mark_is_header : in_header_ff;
      count_now          = req.frame_mark ? 3'd0 : header_count_ff;
      if (accept) begin
         if (implicit_mode) begin
            in_header_in    = 1'b0;
            header_count_in = 3'd0;
            push            = 1'b1;
            if (req.frame_mark && req.mark_is_header) begin
               push_entry.op = OP_IMPLICIT;
            end
         end else if (hdr_now) begin
            if (count_now != HDR_STORED) begin
               // Header nibbles are held back; nothing goes to the back end.
               store_we        = 1'b1;
               store_idx       = count_now[1:0];
               in_header_in    = 1'b1;
               header_count_in = count_now + 1'b1;
            end else begin
               push            = 1'b1;
               push_entry.op   = OP_HEADER;
               in_header_in    = 1'b0;
               header_count_in = 3'd0;
            end
         end else begin
            push            = 1'b1;
            in_header_in    = 1'b0;
            header_count_in = count_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff    <= 1'b0;
         header_count_ff <= 3'd0;
      end else begin
         in_header_ff    <= in_header_in;
         header_count_ff <= header_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         header_store_ff[store_idx] <= req.symbol;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= HDR_STORED)
      else $error("header count beyond four");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !in_header_ff |-> (header_count_ff == 3'd0))
      else $error("header count left over in payload mode");

   a_header_push: assert property (@(posedge clock) disable iff (reset)
      (push && push_entry.op == OP_HEADER) |-> (header_count_ff == HDR_STORED || req.frame_mark))
      else $error("header record queued before four nibbles were gathered");
`endif

endmodule

/* hdl/cfhd_back.sv */
// ----------------------------------------------------------------------------
// Chirp frame header decoder back end
// Turns queued work into result records and holds them in the output register.
// ----------------------------------------------------------------------------
module cfhd_back import cfhd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfhd_cfg_type   cfg,
   input  logic           head_valid,
   input  cfhd_entry_type head,
   output logic           pop,
   cfhd_rsp_if.source     rsp
);

   // Field decode and parity check of a gathered header; n4 is the nibble that completes it.
   function automatic cfhd_rsp_type decode_header(input logic [3:0][3:0] n,
                                                  input logic [3:0] n4);
      cfhd_rsp_type r;
      logic [3:0]   n0, n1, n2, n3;
      logic         c4, c3, c2, c1, c0;
      logic [3:0]   chk_low;
      logic [3:0]   hcrc;
      n0 = n[0];
      n1 = n[1];
      n2 = n[2];
      n3 = n[3];
      c4 = n0[3] ^ n0[2] ^ n0[1] ^ n0[0];
      c3 = n0[3] ^ n1[3] ^ n1[2] ^ n1[1] ^ n2[0];
      c2 = n0[2] ^ n1[3] ^ n1[0] ^ n2[3] ^ n2[1];
      c1 = n0[1] ^ n1[2] ^ n1[0] ^ n2[2] ^ n2[1] ^ n2[0];
      c0 = n0[0] ^ n1[1] ^ n2[3] ^ n2[2] ^ n2[1] ^ n2[0];
      // The checksum is n4 * 8 + 3, so only bit 0 of n4 reaches the low nibble.
      chk_low = {n4[0], 3'b011};
      hcrc    = {2'b00, c4, 1'b0} | n3;
      r.kind           = 1'b1;
      r.data           = 4'd0;
      r.payload_length = {n0, n1};
      r.coding_rate    = n2[3:1];
      r.crc_present    = n2[0];
      r.low_rate_opt   = chk_low[0];
      r.header_error   = ({c3, c2, c1, c0} != chk_low) || (hcrc != 4'b0010);
      r.last           = 1'b1;
      return r;
   endfunction

   logic         rsp_valid_ff, rsp_valid_in;
   cfhd_rsp_type rsp_ff, rsp_in;
   logic         phase_ff, phase_in;
   logic         load;

   assign load = head_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      rsp_in       = '0;
      rsp_in.data  = head.sym;
      rsp_in.last  = 1'b1;
      phase_in     = phase_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         case (head.op)
            OP_IMPLICIT: begin
               if (!phase_ff) begin
                  // Frame information first, the symbol itself on the next transfer.
                  rsp_in.kind           = 1'b1;
                  rsp_in.data           = 4'd0;
                  rsp_in.payload_length = cfg.fixed_payload_length;
                  rsp_in.coding_rate    = cfg.fixed_coding_rate;
                  rsp_in.crc_present    = cfg.fixed_crc_present;
                  rsp_in.low_rate_opt   = cfg.fixed_low_rate_opt;
                  rsp_in.last           = 1'b0;
                  phase_in              = 1'b1;
               end else begin
                  phase_in = 1'b0;
                  pop      = 1'b1;
               end
            end
            OP_HEADER: begin
               rsp_in = decode_header(head.nibbles, head.sym);
               pop    = 1'b1;
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_ff.kind;
   assign rsp.data           = rsp_ff.data;
   assign rsp.payload_length = rsp_ff.payload_length;
   assign rsp.coding_rate    = rsp_ff.coding_rate;
   assign rsp.crc_present    = rsp_ff.crc_present;
   assign rsp.low_rate_opt   = rsp_ff.low_rate_opt;
   assign rsp.header_error   = rsp_ff.header_error;
   assign rsp.last           = rsp_ff.last;

`ifndef NO_ASSERTIONS
   a_phase_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (head_valid && head.op == OP_IMPLICIT))
      else $error("implicit second half pending without its queue entry");

   a_not_last_is_info: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> rsp_ff.kind)
      else $error("non-final result that is not a frame record");

   a_info_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind) |-> (rsp_ff.data == 4'd0))
      else $error("frame record carries symbol data");
`endif

endmodule

/* verif/tb_chirp_frame_header_decoder.sv */
// ----------------------------------------------------------------------------
// Chirp frame header decoder testbench
// Sends symbols with frame marks through the request channel, predicts every
// data result and frame record, and checks the result channel field by field
// across explicit and implicit register settings, with random flow control.
// ----------------------------------------------------------------------------
module tb_chirp_frame_header_decoder;
   import cfhd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       KIND_DATA       = 1'b0;
   localparam logic       KIND_FRAME      = 1'b1;
   localparam logic [2:0] CSR_UNUSED_LOW  = 3'd5;
   localparam logic [2:0] CSR_UNUSED_HIGH = 3'd7;
   localparam int         PHASES          = 8;
   localparam int         RANDOM_BEATS    = 200;
   localparam int         SETTLE_CYCLES   = 8;

   typedef struct packed {
      logic [3:0] symbol;
      logic       frame_mark;
      logic       mark_is_header;
   } symbol_beat_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_en;
   logic [2:0] csr_index;
   logic [7:0] csr_write_data;

   cfhd_req_if req_chan ();
   cfhd_rsp_if rsp_chan ();

   chirp_frame_header_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   // Shadow of the registers and of the header gathering state.
   cfhd_cfg_type    shadow_cfg;
   logic            gathering;
   int              nibble_count;
   logic [3:0]      nibble_store [4];

   symbol_beat_type symbol_queue [$];
   cfhd_rsp_type    decoded_queue [$];
   int              mismatches = 0;

   symbol_beat_type offer;
   logic            offering = 1'b0;
   int              burst_left;
   int              gap_left;
   int              stall_tick;

   // XOR checks over the first three header nibbles, as {c4, c3, c2, c1, c0}.
   function automatic logic [4:0] header_parity(input logic [3:0] n0, n1, n2);
      return {^n0,
              n0[3] ^ n1[3] ^ n1[2] ^ n1[1] ^ n2[0],
              n0[2] ^ n1[3] ^ n1[0] ^ n2[3] ^ n2[1],
              n0[1] ^ n1[2] ^ n1[0] ^ n2[2] ^ n2[1] ^ n2[0],
              n0[0] ^ n1[1] ^ (^n2)};
   endfunction

   function automatic cfhd_rsp_type data_record(input logic [3:0] sym);
      cfhd_rsp_type rec;
      rec = '0;
      rec.kind = KIND_DATA;
      rec.data = sym;
      rec.last = 1'b1;
      return rec;
   endfunction

   task automatic decode_symbol(input symbol_beat_type beat);
      cfhd_rsp_type rec;
      logic [4:0]   par;
      logic [6:0]   chk;
      if (shadow_cfg.implicit_mode) begin
         gathering = 1'b0;
         nibble_count = 0;
         if (beat.frame_mark && beat.mark_is_header) begin
            rec = '0;
            rec.kind = KIND_FRAME;
            rec.payload_length = shadow_cfg.fixed_payload_length;
            rec.coding_rate = shadow_cfg.fixed_coding_rate;
            rec.crc_present = shadow_cfg.fixed_crc_present;
            rec.low_rate_opt = shadow_cfg.fixed_low_rate_opt;
            decoded_queue.push_back(rec);
         end
         decoded_queue.push_back(data_record(beat.symbol));
      end else begin
         if (beat.frame_mark) begin
            gathering = beat.mark_is_header;
            nibble_count = 0;
         end
         if (gathering && nibble_count < 4) begin
            nibble_store[nibble_count] = beat.symbol;
            nibble_count++;
         end else if (gathering) begin
            par = header_parity(nibble_store[0], nibble_store[1], nibble_store[2]);
            chk = {beat.symbol, 3'b011};
            rec = '0;
            rec.kind = KIND_FRAME;
            rec.payload_length = {nibble_store[0], nibble_store[1]};
            rec.coding_rate = nibble_store[2][3:1];
            rec.crc_present = nibble_store[2][0];
            rec.low_rate_opt = chk[0];
            rec.header_error = (par[3:0] != chk[3:0]) ||
                               (({2'b00, par[4], 1'b0} | nibble_store[3]) != 4'd2);
            rec.last = 1'b1;
            decoded_queue.push_back(rec);
            gathering = 1'b0;
            nibble_count = 0;
         end else begin
            decoded_queue.push_back(data_record(beat.symbol));
         end
      end
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         burst_left = 1;
         gap_left = 0;
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            decode_symbol(offer);
            offering = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (symbol_queue.size() > 0) begin
               offer = symbol_queue.pop_front();
               offering = 1'b1;
            end
         end
         req_chan.valid <= offering;
         req_chan.symbol <= offering ? offer.symbol : 4'($urandom);
         req_chan.frame_mark <= offering ? offer.frame_mark : 1'($urandom);
         req_chan.mark_is_header <= offering ? offer.mark_is_header : 1'($urandom);
      end
   end

   // Receiver: steps through four stall patterns in turn on a free-running tick.
   always @(posedge clock) begin
      cfhd_rsp_type got;
      cfhd_rsp_type want;
      if (reset) begin
         stall_tick = 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{kind: rsp_chan.kind, data: rsp_chan.data,
                    payload_length: rsp_chan.payload_length,
                    coding_rate: rsp_chan.coding_rate, crc_present: rsp_chan.crc_present,
                    low_rate_opt: rsp_chan.low_rate_opt,
                    header_error: rsp_chan.header_error, last: rsp_chan.last};
            if (decoded_queue.size() == 0) begin
               $error("result transfer with nothing outstanding: %p", got);
               mismatches++;
            end else begin
               want = decoded_queue.pop_front();
               check_field("kind", want.kind, got.kind);
               check_field("data", want.data, got.data);
               check_field("payload_length", want.payload_length, got.payload_length);
               check_field("coding_rate", want.coding_rate, got.coding_rate);
               check_field("crc_present", want.crc_present, got.crc_present);
               check_field("low_rate_opt", want.low_rate_opt, got.low_rate_opt);
               check_field("header_error", want.header_error, got.header_error);
               check_field("last", want.last, got.last);
            end
         end
         stall_tick++;
         case ((stall_tick / 256) % 4)
            0: begin
               rsp_chan.ready <= 1'b1;
            end
            1: begin
               rsp_chan.ready <= (stall_tick % 4) != 3;
            end
            2: begin
               rsp_chan.ready <= 1'($urandom);
            end
            default: begin
               rsp_chan.ready <= (stall_tick % 16) < 5;
            end
         endcase
      end
   end

   task automatic push_beat(input logic [3:0] sym, input logic mark, input logic hdr);
      symbol_queue.push_back('{symbol: sym, frame_mark: mark, mark_is_header: hdr});
   endtask

   // flaw 0: consistent header, 1: one bit flipped, 2: arbitrary nibbles.
   task automatic push_header(input int flaw);
      logic [3:0]  n0, n1, n2, n3, n4;
      logic [4:0]  par;
      logic [19:0] bits;
      do begin
         n0 = 4'($urandom);
         n1 = 4'($urandom);
         n2 = 4'($urandom);
         par = header_parity(n0, n1, n2);
      end while (flaw != 2 && par[2:0] != 3'b011);
      if (flaw == 2) begin
         n3 = 4'($urandom);
         n4 = 4'($urandom);
      end else begin
         n3 = (par[4] && $urandom_range(0, 1)) ? 4'd0 : 4'd2;
         n4 = {3'($urandom), par[3]};
      end
      bits = {n4, n3, n2, n1, n0};
      if (flaw == 1)
         bits[$urandom_range(0, 19)] ^= 1'b1;
      push_beat(bits[3:0], 1'b1, 1'b1);
      for (int i = 1; i < 5; i++)
         push_beat(bits[4*i +: 4], 1'b0, 1'($urandom));
   endtask

   task automatic add_random_traffic(input int count);
      int target;
      int pick;
      target = symbol_queue.size() + count;
      while (symbol_queue.size() < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 11) begin
            pick = $urandom_range(0, 19);
            push_header(pick < 12 ? 0 : (pick < 17 ? 1 : 2));
            if ($urandom_range(0, 1))
               push_beat(4'($urandom), 1'b1, 1'b0);
            repeat ($urandom_range(0, 6))
               push_beat(4'($urandom), 1'b0, 1'($urandom));
         end else if (pick < 15) begin
            // Header cut short by a payload mark or by a fresh header mark.
            push_beat(4'($urandom), 1'b1, 1'b1);
            repeat ($urandom_range(0, 3))
               push_beat(4'($urandom), 1'b0, 1'($urandom));
            if ($urandom_range(0, 1))
               push_beat(4'($urandom), 1'b1, 1'b0);
            else
               push_header(0);
         end else begin
            repeat ($urandom_range(1, 4))
               push_beat(4'($urandom), 1'($urandom), 1'($urandom));
         end
      end
      // Leave a header half gathered so that the next register change lands mid frame.
      push_beat(4'($urandom), 1'b1, 1'b1);
      push_beat(4'($urandom), 1'b0, 1'($urandom));
   endtask

   task automatic wait_drained();
      while (symbol_queue.size() != 0 || offering || decoded_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      case (index)
         CSR_IMPLICIT_MODE:        shadow_cfg.implicit_mode = value[0];
         CSR_FIXED_CODING_RATE:    shadow_cfg.fixed_coding_rate = value[2:0];
         CSR_FIXED_PAYLOAD_LENGTH: shadow_cfg.fixed_payload_length = value;
         CSR_FIXED_CRC_PRESENT:    shadow_cfg.fixed_crc_present = value[0];
         CSR_FIXED_LOW_RATE_OPT:   shadow_cfg.fixed_low_rate_opt = value[0];
         default: ;
      endcase
   endtask

   // Unused upper data bits are filled at random; the block must ignore them.
   task automatic configure(input logic imp, input logic [2:0] rate,
                            input logic [7:0] len, input logic crc, input logic lro);
      write_csr(CSR_IMPLICIT_MODE, {7'($urandom), imp});
      write_csr(CSR_FIXED_CODING_RATE, {5'($urandom), rate});
      write_csr(CSR_FIXED_PAYLOAD_LENGTH, len);
      write_csr(CSR_FIXED_CRC_PRESENT, {7'($urandom), crc});
      write_csr(CSR_FIXED_LOW_RATE_OPT, {7'($urandom), lro});
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_IMPLICIT_MODE;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.symbol = '0;
      req_chan.frame_mark = 1'b0;
      req_chan.mark_is_header = 1'b0;
      rsp_chan.ready = 1'b0;
      shadow_cfg = '{implicit_mode: 1'b0, fixed_coding_rate: RESET_CODING_RATE,
                     fixed_payload_length: 8'd0, fixed_crc_present: 1'b0,
                     fixed_low_rate_opt: 1'b0};
      gathering = 1'b0;
      nibble_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed start with the reset settings: marks, extreme headers, restarts.
      push_beat(4'hF, 1'b1, 1'b0);
      for (int i = 0; i < 5; i++)
         push_beat(4'h0, i == 0, 1'b1);
      for (int i = 0; i < 5; i++)
         push_beat(4'hF, i == 0, 1'b1);
      push_header(0);
      push_beat(4'h9, 1'b1, 1'b1);
      push_header(0);
      push_beat(4'h3, 1'b1, 1'b1);
      push_beat(4'hC, 1'b0, 1'b1);
      push_beat(4'h6, 1'b0, 1'b0);
      push_beat(4'hA, 1'b1, 1'b0);
      push_beat(4'h0, 1'b0, 1'b1);
      add_random_traffic(RANDOM_BEATS);
      wait_drained();

      for (int phase = 1; phase < PHASES; phase++) begin
         case (phase)
            1: begin
               configure(1'b1, 3'd7, 8'd255, 1'b1, 1'b1);
               push_beat(4'h0, 1'b1, 1'b1);
               push_beat(4'hF, 1'b1, 1'b0);
               push_beat(4'h5, 1'b0, 1'b1);
            end
            3: begin
               configure(1'b1, 3'd0, 8'd0, 1'b0, 1'b0);
            end
            4: begin
               // Writes to indexes past the register list must change nothing.
               write_csr(CSR_UNUSED_LOW, 8'($urandom));
               write_csr(CSR_UNUSED_HIGH, 8'($urandom));
               configure(1'b0, 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
            default: begin
               configure(phase % 2 == 1, 3'($urandom), 8'($urandom), 1'($urandom),
                         1'($urandom));
            end
         endcase
         add_random_traffic(RANDOM_BEATS);
         wait_drained();
      end

      if (mismatches == 0)
         $display("[chirp_frame_header_decoder] OK");
      else
         $display("[chirp_frame_header_decoder] ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[chirp_frame_header_decoder] ERROR");
      $finish;
   end

endmodule

/* chirp_frame_header_decoder.f */
hdl/cfhd_pkg.sv
hdl/cfhd_if.sv
hdl/cfhd_queue.sv
hdl/cfhd_front.sv
hdl/cfhd_back.sv
hdl/chirp_frame_header_decoder.sv
verif/tb_chirp_frame_header_decoder.sv
